// File: src/shifting_array_queue_top_defines.svh
// Assertion helpers used by the checker file.
`ifndef SHIFTING_ARRAY_QUEUE_TOP_DEFINES_SVH
`define SHIFTING_ARRAY_QUEUE_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SAQ_ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("queue check failed");

// Antecedent in one cycle implies the consequent in the next.
`define SAQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("queue sequencing check failed");

`endif

// File: src/saq_pkg.sv
`default_nettype none

package saq_pkg;

   localparam int DEPTH      = 16;
   localparam int ENTRY_W    = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int COUNT_W    = $clog2(DEPTH + 1);
   localparam int OP_W       = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CAP_W      = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // register index taken from the word address bits
   localparam logic [CSR_ADDR_W-3:0] REG_CAPACITY = '0;

   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_PURGE   = 2'd2
   } op_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_REPORT = 1'b1
   } state_type;

   typedef struct packed {
      logic exec;    // perform the accepted request this edge
      logic report;  // result fields are valid this cycle
   } cmd_type;

endpackage

`default_nettype wire

// File: src/saq_csr.sv
`default_nettype none

module saq_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [saq_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [saq_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [saq_pkg::CSR_DATA_W-1:0]   prdata,
   output logic      [saq_pkg::CAP_W-1:0]        capacity
);

   logic [saq_pkg::CAP_W-1:0] capacity_ff;
   logic [saq_pkg::CAP_W-1:0] capacity_in;
   logic                      cap_sel;

   assign cap_sel = (paddr[saq_pkg::CSR_ADDR_W-1:2] == saq_pkg::REG_CAPACITY);

   always_comb begin
      capacity_in = capacity_ff;
      if (psel && penable && pwrite && cap_sel) begin
         capacity_in = pwdata[saq_pkg::CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= saq_pkg::CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign prdata   = cap_sel ? saq_pkg::CSR_DATA_W'(capacity_ff) : '0;
   assign capacity = capacity_ff;

endmodule

`default_nettype wire

// File: src/saq_ctrl.sv
`default_nettype none

module saq_ctrl (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      start,
   output logic           busy,
   output saq_pkg::cmd_type cmd
);

   saq_pkg::state_type state_ff;
   saq_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         saq_pkg::ST_IDLE: begin
            if (start) begin
               state_in = saq_pkg::ST_REPORT;
            end
         end
         saq_pkg::ST_REPORT: begin
            state_in = saq_pkg::ST_IDLE;
         end
         default: begin
            state_in = saq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.exec   = 1'b0;
      cmd.report = 1'b0;
      busy       = reset;
      case (state_ff)
         saq_pkg::ST_IDLE: begin
            cmd.exec = start && !reset;
         end
         saq_pkg::ST_REPORT: begin
            cmd.report = 1'b1;
            busy       = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= saq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: src/saq_datapath.sv
`default_nettype none

module saq_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire saq_pkg::cmd_type              cmd,
   input  wire logic [saq_pkg::OP_W-1:0]      req_operation,
   input  wire logic [saq_pkg::ENTRY_W-1:0]   req_data_in,
   input  wire logic [saq_pkg::CAP_W-1:0]     capacity,
   output logic                               rsp_strobe,
   output logic                               rsp_status,
   output logic      [saq_pkg::ENTRY_W-1:0]   rsp_head_entry,
   output logic      [saq_pkg::ENTRY_W-1:0]   rsp_tail_entry,
   output logic      [saq_pkg::COUNT_W-1:0]   rsp_entry_count,
   output logic                               rsp_is_empty,
   output logic                               rsp_is_full
);

   logic [saq_pkg::ENTRY_W-1:0] slots_ff [saq_pkg::DEPTH];
   logic [saq_pkg::ENTRY_W-1:0] slots_in [saq_pkg::DEPTH];
   logic [saq_pkg::ENTRY_W-1:0] tail_ff;
   logic [saq_pkg::ENTRY_W-1:0] tail_in;
   logic [saq_pkg::COUNT_W-1:0] count_ff;
   logic [saq_pkg::COUNT_W-1:0] count_in;
   logic                        status_ff;
   logic                        status_in;
   logic [saq_pkg::COUNT_W-1:0] cap_eff;
   logic                        empty;
   logic                        full;

   // zero acts as one, anything above the built depth acts as the depth
   always_comb begin
      if (capacity == '0) begin
         cap_eff = saq_pkg::COUNT_W'(1);
      end else if (capacity > saq_pkg::CAP_W'(saq_pkg::DEPTH)) begin
         cap_eff = saq_pkg::COUNT_W'(saq_pkg::DEPTH);
      end else begin
         cap_eff = saq_pkg::COUNT_W'(capacity);
      end
   end

   assign empty = (count_ff == '0);
   assign full  = (count_ff >= cap_eff);

   always_comb begin
      slots_in  = slots_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = status_ff;
      if (cmd.exec) begin
         status_in = 1'b0;
         case (saq_pkg::op_type'(req_operation))
            saq_pkg::OP_ENQUEUE: begin
               if (full) begin
                  status_in = 1'b1;
               end else begin
                  slots_in[count_ff[saq_pkg::IDX_W-1:0]] = req_data_in;
                  tail_in  = req_data_in;
                  count_in = count_ff + saq_pkg::COUNT_W'(1);
               end
            end
            saq_pkg::OP_DEQUEUE: begin
               if (empty) begin
                  status_in = 1'b1;
               end else begin
                  // all slots move one toward the head; the tail entry stays
                  for (int i = 0; i < saq_pkg::DEPTH - 1; i++) begin
                     slots_in[i] = slots_ff[i+1];
                  end
                  count_in = count_ff - saq_pkg::COUNT_W'(1);
               end
            end
            saq_pkg::OP_PURGE: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      slots_ff  <= slots_in;
      tail_ff   <= tail_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp_strobe      = cmd.report;
   assign rsp_status      = status_ff;
   assign rsp_head_entry  = empty ? '0 : slots_ff[0];
   assign rsp_tail_entry  = empty ? '0 : tail_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_is_empty    = empty;
   assign rsp_is_full     = full;

endmodule

`default_nettype wire

// File: src/shifting_array_queue_top.sv
`default_nettype none

// Shift-register queue: head always in slot zero, up to 16 entries of 32 bits.
//
// Request channel: drive req_operation (0 enqueue, 1 dequeue, 2 purge, 3 no-op)
// and req_data_in with start high; the request is taken at the rising edge
// where start is high and busy is low. busy is also high during reset.
// Result channel: rsp_strobe is high for one cycle, the cycle after the
// request is taken, with status, head/tail entries, count and flags valid.
// The receiver cannot stall; results must be sampled on that cycle.
// The controller executes a request (all slots shift in parallel), then reports
// it; busy is high while reporting, so a new request is not taken before the report.
// Config: APB-style, capacity at byte address 0 (5 bits, reset 16). Write it
// only while idle. Zero acts as one, values above 16 act as 16.
// Reset: synchronous, clears count to zero and capacity to 16; slot contents
// are not cleared (only valid slots are ever shown).
// Failed enqueue (full) or dequeue (empty) report status 1 and change nothing.

module shifting_array_queue_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [saq_pkg::OP_W-1:0]         req_operation,
   input  wire logic [saq_pkg::ENTRY_W-1:0]      req_data_in,
   // result channel
   output logic                                  rsp_strobe,
   output logic                                  rsp_status,
   output logic      [saq_pkg::ENTRY_W-1:0]      rsp_head_entry,
   output logic      [saq_pkg::ENTRY_W-1:0]      rsp_tail_entry,
   output logic      [saq_pkg::COUNT_W-1:0]      rsp_entry_count,
   output logic                                  rsp_is_empty,
   output logic                                  rsp_is_full,
   // configuration port
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [saq_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [saq_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [saq_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready
);

   saq_pkg::cmd_type          cmd;
   logic [saq_pkg::CAP_W-1:0] capacity;

   assign pready = 1'b1;

   saq_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .capacity (capacity)
   );

   // two-state sequencer: idle/execute, then report
   saq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // slot array, count, tail copy and status register
   saq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_operation),
      .req_data_in     (req_data_in),
      .capacity        (capacity),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_head_entry  (rsp_head_entry),
      .rsp_tail_entry  (rsp_tail_entry),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

endmodule

`default_nettype wire

// File: src/saq_checker.sv
`default_nettype none

`include "shifting_array_queue_top_defines.svh"

module saq_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           start,
   input wire logic                           busy,
   input wire logic                           rsp_strobe,
   input wire logic [saq_pkg::COUNT_W-1:0]    rsp_entry_count,
   input wire logic                           rsp_is_empty
);

   logic empty_agrees;
   logic count_in_range;

   assign empty_agrees   = (rsp_is_empty == (rsp_entry_count == '0));
   assign count_in_range = (rsp_entry_count <= saq_pkg::COUNT_W'(saq_pkg::DEPTH));

   // every taken request yields a result on the next cycle
   `SAQ_ASSERT_NEXT(a_result_follows, clock, reset, start && !busy, rsp_strobe)

   // no result without a request taken in the previous cycle
   `SAQ_ASSERT_ALWAYS(a_no_spurious, clock, reset, !rsp_strobe || $past(start && !busy))

   // empty flag agrees with the count
   `SAQ_ASSERT_ALWAYS(a_empty_count, clock, reset, !rsp_strobe || empty_agrees)

   // count never exceeds the built depth
   `SAQ_ASSERT_ALWAYS(a_count_bound, clock, reset, !rsp_strobe || count_in_range)

endmodule

bind shifting_array_queue_top saq_checker u_saq_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_entry_count (rsp_entry_count),
   .rsp_is_empty    (rsp_is_empty)
);

`default_nettype wire

// File: verif/tb_top.sv
`default_nettype none

// Checks the shift-register queue: enqueue, dequeue, purge and the unused code,
// capacity at its extremes and lowered below the count. Results are compared
// with a cycle-free model of the queue kept in this module.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // unused operation code: changes nothing, reports success
   localparam logic [saq_pkg::OP_W-1:0] OP_NOP = 2'd3;
   // byte address of the capacity register (word index times four)
   localparam logic [saq_pkg::CSR_ADDR_W-1:0] CAP_ADDR = {saq_pkg::REG_CAPACITY, 2'b00};
   // cycles with no request, result or register access before giving up
   localparam int STALL_LIMIT = 2000;
   localparam int SEG_ITEMS = 156;

   typedef struct packed {
      logic                         status;
      logic [saq_pkg::ENTRY_W-1:0]  head;
      logic [saq_pkg::ENTRY_W-1:0]  tail;
      logic [saq_pkg::COUNT_W-1:0]  count;
      logic                         empty;
      logic                         full;
   } queue_result_type;

   typedef enum logic { ROW_OP, ROW_CAP } row_kind_type;

   // directed row: a request, or a capacity write (value in data)
   typedef struct packed {
      row_kind_type                 kind;
      logic [saq_pkg::OP_W-1:0]     op;
      logic [saq_pkg::ENTRY_W-1:0]  data;
      logic                         pinned;  // known holds the expected result
      queue_result_type             known;
   } script_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic [saq_pkg::OP_W-1:0]       req_operation = '0;
   logic [saq_pkg::ENTRY_W-1:0]    req_data_in = '0;
   logic                           rsp_strobe;
   logic                           rsp_status;
   logic [saq_pkg::ENTRY_W-1:0]    rsp_head_entry;
   logic [saq_pkg::ENTRY_W-1:0]    rsp_tail_entry;
   logic [saq_pkg::COUNT_W-1:0]    rsp_entry_count;
   logic                           rsp_is_empty;
   logic                           rsp_is_full;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [saq_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [saq_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [saq_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   shifting_array_queue_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_data_in     (req_data_in),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_head_entry  (rsp_head_entry),
      .rsp_tail_entry  (rsp_tail_entry),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Queue model: slot 0 is the head, model_count entries are live.
   // ---------------------------------------------------------------------
   logic [saq_pkg::ENTRY_W-1:0] model_slots [saq_pkg::DEPTH];
   int                          model_count = 0;
   logic [saq_pkg::CAP_W-1:0]   model_cap = saq_pkg::CAP_RESET;

   queue_result_type pending_results [$];
   int               fail_count = 0;
   int               quiet_cycles = 0;

   // directed rows may pin the expected result; the model still runs
   logic             pin_valid = 1'b0;
   queue_result_type pin_result = '0;

   function automatic queue_result_type apply_queue_op(
         input logic [saq_pkg::OP_W-1:0] op,
         input logic [saq_pkg::ENTRY_W-1:0] word);
      queue_result_type r;
      int               eff_cap;
      // zero behaves as one, anything above the built depth as the depth
      eff_cap = (model_cap == 0) ? 1 :
                (model_cap > saq_pkg::DEPTH) ? saq_pkg::DEPTH : int'(model_cap);
      r = '0;
      case (op)
         saq_pkg::OP_ENQUEUE: begin
            // full also covers a capacity lowered below the count
            if (model_count >= eff_cap) r.status = 1'b1;
            else begin
               model_slots[model_count] = word;
               model_count++;
            end
         end
         saq_pkg::OP_DEQUEUE: begin
            if (model_count == 0) r.status = 1'b1;
            else begin
               for (int i = 0; i + 1 < model_count; i++) model_slots[i] = model_slots[i + 1];
               model_count--;
            end
         end
         saq_pkg::OP_PURGE: model_count = 0;
         default: ;  // unused code: no change, success
      endcase
      // head and tail read as zero on an empty queue
      if (model_count != 0) begin
         r.head = model_slots[0];
         r.tail = model_slots[model_count - 1];
      end
      r.count = saq_pkg::COUNT_W'(model_count);
      r.empty = (model_count == 0);
      r.full  = (model_count >= eff_cap);
      return r;
   endfunction

   task automatic compare_result(input queue_result_type want);
      if (rsp_status !== want.status) begin
         $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_status);
         fail_count++;
      end
      if (rsp_head_entry !== want.head) begin
         $display("%0t: head expected %h, got %h", $time, want.head, rsp_head_entry);
         fail_count++;
      end
      if (rsp_tail_entry !== want.tail) begin
         $display("%0t: tail expected %h, got %h", $time, want.tail, rsp_tail_entry);
         fail_count++;
      end
      if (rsp_entry_count !== want.count) begin
         $display("%0t: count expected %0d, got %0d", $time, want.count, rsp_entry_count);
         fail_count++;
      end
      if (rsp_is_empty !== want.empty) begin
         $display("%0t: empty expected %0d, got %0d", $time, want.empty, rsp_is_empty);
         fail_count++;
      end
      if (rsp_is_full !== want.full) begin
         $display("%0t: full expected %0d, got %0d", $time, want.full, rsp_is_full);
         fail_count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Monitor. Everything is sampled on the falling edge, away from the rising
   // edge where the DUT and the drivers update, so nothing here depends on
   // scheduling order. A handshake seen high here completes at the next rising
   // edge.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         // result first: it belongs to a request accepted earlier
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result with nothing expected (status %0d, count %0d)",
                        $time, rsp_status, rsp_entry_count);
               fail_count++;
            end else compare_result(pending_results.pop_front());
         end
         if (start && !busy) begin
            queue_result_type want;
            want = apply_queue_op(req_operation, req_data_in);
            if (pin_valid) want = pin_result;
            pending_results.push_back(want);
         end
         // watchdog: any request, result or register access counts as progress
         if ((start && !busy) || rsp_strobe || psel) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("shifting_array_queue_top test failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Drivers. Called and returning on a rising edge.
   // ---------------------------------------------------------------------

   // Hold the request until busy is low at an edge; returns on that edge.
   task automatic push_request(input logic [saq_pkg::OP_W-1:0] op,
                               input logic [saq_pkg::ENTRY_W-1:0] word);
      logic took;
      req_operation <= op;
      req_data_in   <= word;
      start         <= 1'b1;
      do begin
         @(negedge clock);
         took = !busy;
         @(posedge clock);
      end while (!took);
   endtask

   // Capacity changes only while idle: drain results, let the last one settle,
   // write it (upper bits random, only five are kept), then read it back.
   task automatic write_capacity(input logic [saq_pkg::CAP_W-1:0] cap_val);
      logic [saq_pkg::CSR_DATA_W-1:0] word;
      word = $urandom();
      word[saq_pkg::CAP_W-1:0] = cap_val;
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= CAP_ADDR;
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      // the write lands on this edge
      model_cap = cap_val;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      if (prdata !== saq_pkg::CSR_DATA_W'(cap_val)) begin
         $display("%0t: capacity readback expected %h, got %h", $time,
                  saq_pkg::CSR_DATA_W'(cap_val), prdata);
         fail_count++;
      end
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Directed part. Pinned rows carry results that follow directly from the
   // queue contents; the rest are left to the model.
   // ---------------------------------------------------------------------
   script_row_type script [24] = '{
      // dequeue on the empty queue right after reset fails
      '{ROW_OP,  saq_pkg::OP_DEQUEUE, 32'h0000_0000, 1'b1,
        '{1'b1, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b0}},
      // data extremes
      '{ROW_OP,  saq_pkg::OP_ENQUEUE, 32'hFFFF_FFFF, 1'b1,
        '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1, 1'b0, 1'b0}},
      '{ROW_OP,  saq_pkg::OP_ENQUEUE, 32'h0000_0000, 1'b1,
        '{1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 5'd2, 1'b0, 1'b0}},
      '{ROW_OP,  saq_pkg::OP_ENQUEUE, 32'hA5A5_A5A5, 1'b0, '0},
      // unused code with data present
      '{ROW_OP,  OP_NOP,              32'h5A5A_0F0F, 1'b0, '0},
      '{ROW_OP,  saq_pkg::OP_DEQUEUE, 32'h0000_0000, 1'b0, '0},
      '{ROW_OP,  saq_pkg::OP_PURGE,   32'hC3C3_C3C3, 1'b1,
        '{1'b0, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b0}},
      // capacity zero behaves as one
      '{ROW_CAP, OP_NOP,              32'd0,         1'b0, '0},
      '{ROW_OP,  saq_pkg::OP_ENQUEUE, 32'h1234_5678, 1'b1,
        '{1'b0, 32'h1234_5678, 32'h1234_5678, 5'd1, 1'b0, 1'b1}},
      '{ROW_OP,  saq_pkg::OP_ENQUEUE, 32'h5555_5555, 1'b1,
        '{1'b1, 32'h1234_5678, 32'h1234_5678, 5'd1, 1'b0, 1'b1}},
      '{ROW_OP,  saq_pkg::OP_DEQUEUE, 32'h0000_0000, 1'b1,
        '{1'b0, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b0}},
      '{ROW_OP,  saq_pkg::OP_DEQUEUE, 32'hFFFF_FFFF, 1'b1,
        '{1'b1, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b0}},
      // fill a small queue, then lower the capacity under the count
      '{ROW_CAP, OP_NOP,              32'd3,         1'b0, '0},
      '{ROW_OP,  saq_pkg::OP_ENQUEUE, 32'h0000_0001, 1'b0, '0},
      '{ROW_OP,  saq_pkg::OP_ENQUEUE, 32'h8000_0000, 1'b0, '0},
      '{ROW_OP,  saq_pkg::OP_ENQUEUE, 32'hDEAD_BEEF, 1'b0, '0},
      '{ROW_OP,  saq_pkg::OP_ENQUEUE, 32'h0F0F_0F0F, 1'b0, '0},
      '{ROW_CAP, OP_NOP,              32'd2,         1'b0, '0},
      '{ROW_OP,  saq_pkg::OP_ENQUEUE, 32'h1111_1111, 1'b0, '0},
      '{ROW_OP,  saq_pkg::OP_DEQUEUE, 32'h0000_0000, 1'b0, '0},
      '{ROW_OP,  saq_pkg::OP_DEQUEUE, 32'h0000_0000, 1'b0, '0},
      // above the built depth behaves as the depth
      '{ROW_CAP, OP_NOP,              32'd31,        1'b0, '0},
      '{ROW_OP,  saq_pkg::OP_PURGE,   32'h0000_0000, 1'b0, '0},
      '{ROW_OP,  OP_NOP,              32'hFFFF_FFFF, 1'b0, '0}
   };

   // per segment: capacity (index 5 replaced by a random value) and the
   // sender's idle percentage
   logic [saq_pkg::CAP_W-1:0] seg_caps [8] =
      '{5'd16, 5'd0, 5'd31, 5'd7, 5'd1, 5'd12, 5'd2, 5'd16};
   int                        seg_idle [8] = '{0, 79, 31, 0, 79, 31, 0, 79};

   initial begin
      int                          idle_pct;
      int                          burst_left;
      int                          mode;
      int                          pick;
      int                          enq_pct;
      logic [saq_pkg::OP_W-1:0]    op;
      logic [saq_pkg::ENTRY_W-1:0] word;
      logic [saq_pkg::CAP_W-1:0]   cap_val;

      burst_left = 0;
      mode = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].kind == ROW_CAP) write_capacity(script[i].data[saq_pkg::CAP_W-1:0]);
         else begin
            pin_valid  = script[i].pinned;
            pin_result = script[i].known;
            push_request(script[i].op, script[i].data);
            pin_valid  = 1'b0;
         end
      end

      // Random part: bursts that mostly fill, mostly drain, or mix, so the
      // queue swings between empty and full at every capacity setting.
      for (int seg = 0; seg < 8; seg++) begin
         cap_val = (seg == 5) ? saq_pkg::CAP_W'($urandom_range(31)) : seg_caps[seg];
         write_capacity(cap_val);
         idle_pct = seg_idle[seg];
         for (int n = 0; n < SEG_ITEMS; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(24, 4);
               mode = $urandom_range(2);
            end
            burst_left--;
            enq_pct = (mode == 0) ? 85 : (mode == 1) ? 12 : 50;
            pick = $urandom_range(99);
            if (pick < 1) op = saq_pkg::OP_PURGE;
            else if (pick < 4) op = OP_NOP;
            else if ($urandom_range(99) < enq_pct) op = saq_pkg::OP_ENQUEUE;
            else op = saq_pkg::OP_DEQUEUE;
            case ($urandom_range(7))
               0: word = '0;
               1: word = '1;
               default: word = $urandom();
            endcase
            // now and then hold off until every result is back
            if ($urandom_range(99) == 0) begin
               start <= 1'b0;
               @(posedge clock);
               while (pending_results.size() != 0) @(posedge clock);
            end
            while ($urandom_range(99) < idle_pct) begin
               start <= 1'b0;
               @(posedge clock);
            end
            push_request(op, word);
         end
      end

      // drain, then give the last result time to show up or misbehave
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("shifting_array_queue_top test passed");
      end else begin
         $display("shifting_array_queue_top test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
